// ===== hw/rtl/bkhs_pkg.sv =====
// ----------------------------------------------------------------------------
// bkhs_pkg
// Shared types and constants of the bottom-k hash selector.
// ----------------------------------------------------------------------------
`default_nettype none
package bkhs_pkg;

    localparam int MAX_KEEP   = 256;
    localparam int ADDR_W     = $clog2(MAX_KEEP);
    localparam int FILL_W     = $clog2(MAX_KEEP + 1);
    localparam int KEY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the input beat.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WEIGHTED  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_KEEP      = 2'd2;

    localparam logic [8:0] KEEP_RESET = 9'd256;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_INS,
        KIND_POP,
        KIND_CLR
    } t_kind;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        t_kind  kind;
        t_entry entry;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/bkhs_front.sv =====
// ----------------------------------------------------------------------------
// bkhs_front
// Accepts command beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bkhs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [1:0]                    i_op,
    input  wire logic [bkhs_pkg::KEY_W-1:0]    i_key,
    input  wire logic [bkhs_pkg::CNT_W-1:0]    i_count,
    input  wire logic [bkhs_pkg::CNT_W-1:0]    i_threshold,
    output logic                               o_busy,
    output logic                               o_q_valid,
    output bkhs_pkg::t_cmd                     o_q_cmd,
    input  wire logic                          i_q_take
);

    bkhs_pkg::t_cmd r_q [bkhs_pkg::QUEUE_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           accept;
    bkhs_pkg::t_cmd cls;

    assign o_busy    = (r_cnt == 2'(bkhs_pkg::QUEUE_DEPTH));
    assign accept    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd_ptr];

    // Classify the beat; inserts at or below the threshold become no-ops here.
    always_comb begin
        cls.entry.key   = i_key;
        cls.entry.count = i_count;
        case (i_op)
            bkhs_pkg::OP_INSERT: begin
                cls.kind = (i_count > i_threshold) ? bkhs_pkg::KIND_INS : bkhs_pkg::KIND_NOP;
            end
            bkhs_pkg::OP_POP:   cls.kind = bkhs_pkg::KIND_POP;
            bkhs_pkg::OP_CLEAR: cls.kind = bkhs_pkg::KIND_CLR;
            default:            cls.kind = bkhs_pkg::KIND_NOP;
        endcase
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_q_take);
        end
    end

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_take |-> r_cnt != 2'd0) else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(bkhs_pkg::QUEUE_DEPTH)) else $error("queue overfilled");

endmodule
`default_nettype wire

// ===== hw/rtl/bkhs_cmp.sv =====
// ----------------------------------------------------------------------------
// bkhs_cmp
// Three-stage ordering compare: is entry a strictly below entry b.
// ----------------------------------------------------------------------------
`default_nettype none
module bkhs_cmp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_weighted,
    input  bkhs_pkg::t_entry     i_a,
    input  bkhs_pkg::t_entry     i_b,
    output logic                 o_done,
    output logic                 o_below
);

    logic             r_v1, r_v2;
    logic             r_w1, r_w2;
    logic [63:0]      r_ka1, r_kb1, r_ka2, r_kb2;
    logic [31:0]      r_ca1, r_cb1;
    logic [63:0]      r_pal, r_pah, r_pbl, r_pbh;
    logic [95:0]      lhs, rhs;

    // Stage one: latch operands. Stage two: partial products.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ka1 <= i_a.key;
            r_ca1 <= i_a.count;
            r_kb1 <= i_b.key;
            r_cb1 <= i_b.count;
            r_w1  <= i_weighted;
        end
        r_pal <= 64'(r_ka1[31:0])  * 64'(r_cb1);
        r_pah <= 64'(r_ka1[63:32]) * 64'(r_cb1);
        r_pbl <= 64'(r_kb1[31:0])  * 64'(r_ca1);
        r_pbh <= 64'(r_kb1[63:32]) * 64'(r_ca1);
        r_ka2 <= r_ka1;
        r_kb2 <= r_kb1;
        r_w2  <= r_w1;
    end

    // Stage three: combine partial products into 96-bit values and compare.
    assign lhs = {r_pah, 32'd0} + {32'd0, r_pal};
    assign rhs = {r_pbh, 32'd0} + {32'd0, r_pbl};

    always_ff @(posedge i_clk) begin
        if (r_w2 && (lhs != rhs)) begin
            o_below <= (lhs < rhs);
        end else begin
            o_below <= (r_ka2 < r_kb2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            o_done <= r_v2;
        end
    end

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 3)) else $error("compare done without start");

endmodule
`default_nettype wire

// ===== hw/rtl/bkhs_heap.sv =====
// ----------------------------------------------------------------------------
// bkhs_heap
// Heap engine: runs insert, pop and clear on a max-heap held in memory.
// ----------------------------------------------------------------------------
`default_nettype none
module bkhs_heap (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_weighted,
    input  wire logic [8:0]                    i_keep,
    input  wire logic                          i_q_valid,
    input  bkhs_pkg::t_cmd                     i_q_cmd,
    output logic                               o_q_take,
    output logic                               o_result_valid,
    output logic [bkhs_pkg::KEY_W-1:0]         o_popped_key,
    output logic                               o_was_empty
);

    typedef enum logic [3:0] {
        S_IDLE, S_P_TOP, S_P_LAST, S_I_TOP, S_I_WAIT,
        S_UP_CHK, S_UP_RD, S_UP_WAIT,
        S_DN_L, S_DN_LRD, S_DN_LW, S_DN_RRD, S_DN_RW, S_DN_DEC
    } t_state;

    typedef enum logic [1:0] {
        BIG_SELF, BIG_LEFT, BIG_RIGHT
    } t_big;

    localparam int IDX_W = bkhs_pkg::ADDR_W + 2;

    t_state                            r_state;
    logic [bkhs_pkg::FILL_W-1:0]       r_fill;
    logic [bkhs_pkg::ADDR_W-1:0]       r_pos;
    bkhs_pkg::t_entry                  r_x;
    bkhs_pkg::t_entry                  r_big;
    t_big                              r_big_sel;
    bkhs_pkg::t_entry                  r_rdata;
    bkhs_pkg::t_entry                  mem [bkhs_pkg::MAX_KEEP];

    logic [bkhs_pkg::FILL_W-1:0]       limit;
    logic [IDX_W-1:0]                  l_idx, r_idx, fill_x;
    logic                              l_ok, r_ok;
    logic [bkhs_pkg::ADDR_W-1:0]       pos_m1, parent;
    logic                              rd_en, wr_en;
    logic [bkhs_pkg::ADDR_W-1:0]       rd_addr, wr_addr;
    bkhs_pkg::t_entry                  wr_data;
    logic                              cmp_start, cmp_done, cmp_below;
    bkhs_pkg::t_entry                  cmp_a, cmp_b;
    logic                              has_room;

    // The entry limit: a keep count of zero counts as one, above the capacity saturates.
    always_comb begin
        if (i_keep == 9'd0) begin
            limit = bkhs_pkg::FILL_W'(1);
        end else if (32'(i_keep) > 32'(bkhs_pkg::MAX_KEEP)) begin
            limit = bkhs_pkg::FILL_W'(bkhs_pkg::MAX_KEEP);
        end else begin
            limit = bkhs_pkg::FILL_W'(i_keep);
        end
    end

    assign has_room = (r_fill < limit);
    assign fill_x   = IDX_W'(r_fill);
    assign l_idx    = {1'b0, r_pos, 1'b1};
    assign r_idx    = l_idx + IDX_W'(1);
    assign l_ok     = (l_idx < fill_x);
    assign r_ok     = (r_idx < fill_x);
    assign pos_m1   = r_pos - bkhs_pkg::ADDR_W'(1);
    assign parent   = {1'b0, pos_m1[bkhs_pkg::ADDR_W-1:1]};

    // Memory, compare and queue controls for each state.
    always_comb begin
        o_q_take  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_x;
        cmp_start = 1'b0;
        cmp_a     = r_x;
        cmp_b     = r_rdata;
        case (r_state)
            S_IDLE: begin
                o_q_take = i_q_valid;
                if (i_q_valid && i_q_cmd.kind == bkhs_pkg::KIND_POP && r_fill != '0) begin
                    rd_en = 1'b1;
                end
                if (i_q_valid && i_q_cmd.kind == bkhs_pkg::KIND_INS && !has_room) begin
                    rd_en = 1'b1;
                end
            end
            S_P_TOP: begin
                if (r_fill > bkhs_pkg::FILL_W'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = bkhs_pkg::ADDR_W'(r_fill - bkhs_pkg::FILL_W'(1));
                end
            end
            S_I_TOP: begin
                cmp_start = 1'b1;
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            S_UP_RD: begin
                cmp_start = 1'b1;
                cmp_a     = r_rdata;
                cmp_b     = r_x;
            end
            S_UP_WAIT: begin
                if (cmp_done) begin
                    wr_en   = 1'b1;
                    wr_data = cmp_below ? r_rdata : r_x;
                end
            end
            S_DN_L: begin
                if (l_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = l_idx[bkhs_pkg::ADDR_W-1:0];
                end else begin
                    wr_en = 1'b1;
                end
            end
            S_DN_LRD: begin
                cmp_start = 1'b1;
            end
            S_DN_LW: begin
                if (cmp_done && r_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[bkhs_pkg::ADDR_W-1:0];
                end
            end
            S_DN_RRD: begin
                cmp_start = 1'b1;
                cmp_a     = r_big;
            end
            S_DN_DEC: begin
                wr_en   = 1'b1;
                wr_data = (r_big_sel == BIG_SELF) ? r_x : r_big;
            end
            default: begin
            end
        endcase
    end

    // Heap storage with registered read.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    bkhs_cmp u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cmp_start),
        .i_weighted (i_weighted),
        .i_a        (cmp_a),
        .i_b        (cmp_b),
        .o_done     (cmp_done),
        .o_below    (cmp_below)
    );

    // Sequencer state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fill         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_x <= i_q_cmd.entry;
                        case (i_q_cmd.kind)
                            bkhs_pkg::KIND_CLR: r_fill <= '0;
                            bkhs_pkg::KIND_POP: begin
                                if (r_fill == '0) begin
                                    o_result_valid <= 1'b1;
                                    o_popped_key   <= '1;
                                    o_was_empty    <= 1'b1;
                                end else begin
                                    r_state <= S_P_TOP;
                                end
                            end
                            bkhs_pkg::KIND_INS: begin
                                if (has_room) begin
                                    r_pos   <= bkhs_pkg::ADDR_W'(r_fill);
                                    r_fill  <= r_fill + bkhs_pkg::FILL_W'(1);
                                    r_state <= S_UP_CHK;
                                end else begin
                                    r_state <= S_I_TOP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_P_TOP: begin
                    o_result_valid <= 1'b1;
                    o_popped_key   <= r_rdata.key;
                    o_was_empty    <= 1'b0;
                    r_fill         <= r_fill - bkhs_pkg::FILL_W'(1);
                    r_state        <= (r_fill > bkhs_pkg::FILL_W'(1)) ? S_P_LAST : S_IDLE;
                end
                S_P_LAST: begin
                    r_x     <= r_rdata;
                    r_pos   <= '0;
                    r_state <= S_DN_L;
                end
                S_I_TOP: r_state <= S_I_WAIT;
                S_I_WAIT: begin
                    if (cmp_done) begin
                        r_pos   <= '0;
                        r_state <= cmp_below ? S_DN_L : S_IDLE;
                    end
                end
                S_UP_CHK: r_state <= (r_pos == '0) ? S_IDLE : S_UP_RD;
                S_UP_RD:  r_state <= S_UP_WAIT;
                S_UP_WAIT: begin
                    if (cmp_done) begin
                        if (cmp_below) begin
                            r_pos   <= parent;
                            r_state <= S_UP_CHK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DN_L: r_state <= l_ok ? S_DN_LRD : S_IDLE;
                S_DN_LRD: begin
                    r_big   <= r_rdata;
                    r_state <= S_DN_LW;
                end
                S_DN_LW: begin
                    if (cmp_done) begin
                        if (cmp_below) begin
                            r_big_sel <= BIG_LEFT;
                        end else begin
                            r_big_sel <= BIG_SELF;
                            r_big     <= r_x;
                        end
                        r_state <= r_ok ? S_DN_RRD : S_DN_DEC;
                    end
                end
                S_DN_RRD: r_state <= S_DN_RW;
                S_DN_RW: begin
                    if (cmp_done) begin
                        if (cmp_below) begin
                            r_big     <= r_rdata;
                            r_big_sel <= BIG_RIGHT;
                        end
                        r_state <= S_DN_DEC;
                    end
                end
                S_DN_DEC: begin
                    case (r_big_sel)
                        BIG_LEFT: begin
                            r_pos   <= l_idx[bkhs_pkg::ADDR_W-1:0];
                            r_state <= S_DN_L;
                        end
                        BIG_RIGHT: begin
                            r_pos   <= r_idx[bkhs_pkg::ADDR_W-1:0];
                            r_state <= S_DN_L;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= bkhs_pkg::FILL_W'(bkhs_pkg::MAX_KEEP)) else $error("heap overfilled");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |-> r_state == S_IDLE) else $error("command taken while working");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_was_empty) |-> $past(r_fill) != '0)
        else $error("pop result from an empty heap");

endmodule
`default_nettype wire

// ===== hw/rtl/bottom_k_hash_selector.sv =====
// ----------------------------------------------------------------------------
// bottom_k_hash_selector
// Keeps the smallest keys of a hash stream in a bounded max-heap.
// ----------------------------------------------------------------------------
// A command beat (op, key, count) is taken at a rising edge where start is
// high and busy is low. Op selects insert, pop or clear. Inserts whose count
// is not above the threshold become no-ops at the front; every taken beat
// joins a two-entry command queue, so busy rises only when it is full.
// The heap engine takes one command at a time. A pop gives one result beat,
// shown for exactly one cycle with o_result_valid high; the receiver cannot
// stall it. A pop reads the heap top over the registered memory read. Each
// heap level costs a registered memory read and a three-stage compare (two
// 64x32 products split into 32x32 partial products) per child, so an item's
// work grows with heap depth, up to 256 entries. Insert and clear give no
// result beat. Configuration: index 0 weighted mode, 1 count threshold, 2
// keep count, written over i_cfg_valid/o_cfg_ready; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Reset empties the heap and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module bottom_k_hash_selector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [bkhs_pkg::KEY_W-1:0]    i_key,
    input  wire logic [bkhs_pkg::CNT_W-1:0]    i_count,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    output logic                               o_result_valid,
    output logic [bkhs_pkg::KEY_W-1:0]         o_popped_key,
    output logic                               o_was_empty
);

    logic                       r_weighted;
    logic [bkhs_pkg::CNT_W-1:0] r_threshold;
    logic [8:0]                 r_keep;
    logic                       q_valid, q_take;
    bkhs_pkg::t_cmd             q_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weighted  <= 1'b0;
            r_threshold <= '0;
            r_keep      <= bkhs_pkg::KEEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bkhs_pkg::CFG_WEIGHTED:  r_weighted  <= i_cfg_data[0];
                bkhs_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                bkhs_pkg::CFG_KEEP:      r_keep      <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    bkhs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_count     (i_count),
        .i_threshold (r_threshold),
        .o_busy      (busy),
        .o_q_valid   (q_valid),
        .o_q_cmd     (q_cmd),
        .i_q_take    (q_take)
    );

    bkhs_heap u_heap (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_weighted     (r_weighted),
        .i_keep         (r_keep),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_take       (q_take),
        .o_result_valid (o_result_valid),
        .o_popped_key   (o_popped_key),
        .o_was_empty    (o_was_empty)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bottom-k hash selector: a directed table of
// command beats, then random insert/pop/clear traffic under several idling
// phases and register settings, each pop beat checked against a heap model.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    // Op value with no meaning; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_op = bkhs_pkg::OP_INSERT;
    logic [bkhs_pkg::KEY_W-1:0] i_key = '0;
    logic [bkhs_pkg::CNT_W-1:0] i_count = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = bkhs_pkg::CFG_WEIGHTED;
    logic [31:0] i_cfg_data = '0;
    logic o_result_valid;
    logic [bkhs_pkg::KEY_W-1:0] o_popped_key;
    logic o_was_empty;

    bottom_k_hash_selector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_key(i_key), .i_count(i_count),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_popped_key(o_popped_key),
        .o_was_empty(o_was_empty)
    );

    // Clock: period 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Model heap and registers.
    logic [bkhs_pkg::KEY_W-1:0] mdl_keys [bkhs_pkg::MAX_KEEP];
    logic [bkhs_pkg::CNT_W-1:0] mdl_counts [bkhs_pkg::MAX_KEEP];
    int unsigned mdl_fill;
    bit mdl_weighted;
    logic [31:0] mdl_threshold;
    logic [8:0] mdl_keep;

    typedef struct {
        logic [bkhs_pkg::KEY_W-1:0] key;
        logic                       empty;
    } t_pop_beat;
    t_pop_beat pending_pops[$];

    int fail_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;

    // Ordering of (ka,ca) strictly below (kb,cb).
    function automatic bit entry_below(logic [63:0] ka, logic [31:0] ca,
                                       logic [63:0] kb, logic [31:0] cb);
        logic [95:0] lp;
        logic [95:0] rp;
        lp = {32'b0, ka} * {64'b0, cb};
        rp = {32'b0, kb} * {64'b0, ca};
        if (mdl_weighted && lp != rp) return lp < rp;
        return ka < kb;
    endfunction

    function automatic bit slot_below(int unsigned a, int unsigned b);
        return entry_below(mdl_keys[a], mdl_counts[a], mdl_keys[b], mdl_counts[b]);
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [63:0] tk;
        logic [31:0] tc;
        tk = mdl_keys[a]; tc = mdl_counts[a];
        mdl_keys[a] = mdl_keys[b]; mdl_counts[a] = mdl_counts[b];
        mdl_keys[b] = tk; mdl_counts[b] = tc;
    endfunction

    function automatic void sift_down_top();
        int unsigned pos;
        int unsigned lc;
        int unsigned big;
        pos = 0;
        forever begin
            lc = 2 * pos + 1;
            big = pos;
            if (lc < mdl_fill && slot_below(big, lc)) big = lc;
            if (lc + 1 < mdl_fill && slot_below(big, lc + 1)) big = lc + 1;
            if (big == pos) break;
            swap_slots(pos, big);
            pos = big;
        end
    endfunction

    // Apply one accepted command beat to the model heap.
    function automatic void heap_apply(logic [1:0] op, logic [63:0] key, logic [31:0] cnt);
        int unsigned lim;
        int unsigned pos;
        t_pop_beat pb;
        lim = (mdl_keep == 0) ? 1 :
              ((mdl_keep > bkhs_pkg::MAX_KEEP) ? bkhs_pkg::MAX_KEEP : mdl_keep);
        if (op == bkhs_pkg::OP_INSERT) begin
            if (cnt <= mdl_threshold) return;
            if (mdl_fill < lim) begin
                mdl_keys[mdl_fill] = key;
                mdl_counts[mdl_fill] = cnt;
                pos = mdl_fill;
                mdl_fill++;
                while (pos > 0 && slot_below((pos - 1) / 2, pos)) begin
                    swap_slots((pos - 1) / 2, pos);
                    pos = (pos - 1) / 2;
                end
            end else if (mdl_fill > 0 && entry_below(key, cnt, mdl_keys[0], mdl_counts[0])) begin
                mdl_keys[0] = key;
                mdl_counts[0] = cnt;
                sift_down_top();
            end
        end else if (op == bkhs_pkg::OP_POP) begin
            if (mdl_fill == 0) begin
                pb.key = '1; pb.empty = 1'b1;
            end else begin
                pb.key = mdl_keys[0]; pb.empty = 1'b0;
                mdl_fill--;
                if (mdl_fill > 0) begin
                    mdl_keys[0] = mdl_keys[mdl_fill];
                    mdl_counts[0] = mdl_counts[mdl_fill];
                    sift_down_top();
                end
            end
            pending_pops.push_back(pb);
        end else if (op == bkhs_pkg::OP_CLEAR) begin
            mdl_fill = 0;
        end
    endfunction

    // Result checking: every strobe is one accepted result beat.
    always @(posedge i_clk) begin
        t_pop_beat exp_beat;
        if (i_rst_n && o_result_valid) begin
            idle_cycles <= 0;
            if (pending_pops.size() == 0) begin
                $error("result beat with no pop pending: key %h", o_popped_key);
                fail_count++;
            end else begin
                exp_beat = pending_pops.pop_front();
                if (o_popped_key !== exp_beat.key) begin
                    $error("popped_key expected %h actual %h", exp_beat.key, o_popped_key);
                    fail_count++;
                end
                if (o_was_empty !== exp_beat.empty) begin
                    $error("was_empty expected %0d actual %0d", exp_beat.empty, o_was_empty);
                    fail_count++;
                end
            end
        end else if (i_rst_n && !(start && !busy)) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
    end

    // Watchdog on cycles with no beat accepted and no result beat.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one command beat, with random idle gaps ahead of it. Start stays
    // high between back-to-back beats and drops only while the sender idles.
    task automatic send_cmd(logic [1:0] op, logic [63:0] key, logic [31:0] cnt);
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_key <= key;
        i_count <= cnt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        heap_apply(op, key, cnt);
    endtask

    // Wait until every pop beat has come out, then let the engine settle.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_pops.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == bkhs_pkg::CFG_WEIGHTED) mdl_weighted = val[0];
        else if (idx == bkhs_pkg::CFG_THRESHOLD) mdl_threshold = val;
        else if (idx == bkhs_pkg::CFG_KEEP) mdl_keep = val[8:0];
    endtask

    function automatic logic [63:0] rand_key();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {32'b0, $urandom_range(63)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1;
            2: return 32'd0;
            3: return $urandom;
            default: return $urandom_range(8, 1);
        endcase
    endfunction

    // Directed table of command beats.
    typedef struct {
        logic [1:0]  op;
        logic [63:0] key;
        logic [31:0] cnt;
    } t_row;

    t_row directed_rows[] = '{
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_INSERT, 64'h0, 32'd0},
        '{bkhs_pkg::OP_INSERT, 64'h0, 32'd1},
        '{bkhs_pkg::OP_INSERT, '1, 32'hFFFF_FFFF},
        '{bkhs_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 32'd7},
        '{bkhs_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA},
        '{OP_UNUSED,           64'h1234, 32'd5},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_CLEAR,  64'h0, 32'd0},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_INSERT, 64'h20, 32'd3},
        '{bkhs_pkg::OP_INSERT, 64'h10, 32'd9},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0},
        '{bkhs_pkg::OP_POP,    64'h0, 32'd0}
    };

    // Run one phase of random traffic: mostly inserts, some pops, rare clears.
    task automatic random_phase(int n_items, int idle_pct);
        int unsigned r;
        send_idle_pct = idle_pct;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 60) send_cmd(bkhs_pkg::OP_INSERT, rand_key(), rand_count());
            else if (r < 96) send_cmd(bkhs_pkg::OP_POP, rand_key(), rand_count());
            else if (r < 98) send_cmd(bkhs_pkg::OP_CLEAR, rand_key(), rand_count());
            else send_cmd(OP_UNUSED, rand_key(), rand_count());
        end
    endtask

    initial begin
        mdl_fill = 0;
        mdl_weighted = 1'b0;
        mdl_threshold = '0;
        mdl_keep = bkhs_pkg::KEEP_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, under reset settings.
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].op, directed_rows[i].key, directed_rows[i].cnt);

        // Weighted ordering with small keep count and a ratio tie.
        write_reg(bkhs_pkg::CFG_WEIGHTED, 32'd1);
        write_reg(bkhs_pkg::CFG_KEEP, 32'd2);
        send_cmd(bkhs_pkg::OP_INSERT, 64'd6, 32'd3);
        send_cmd(bkhs_pkg::OP_INSERT, 64'd4, 32'd2);
        send_cmd(bkhs_pkg::OP_INSERT, 64'd2, 32'd1);
        send_cmd(bkhs_pkg::OP_INSERT, 64'd1, 32'd4);
        send_cmd(bkhs_pkg::OP_POP, 64'd0, 32'd0);
        send_cmd(bkhs_pkg::OP_POP, 64'd0, 32'd0);
        send_cmd(bkhs_pkg::OP_POP, 64'd0, 32'd0);

        // Phases over several settings, extremes among them.
        write_reg(bkhs_pkg::CFG_KEEP, 32'd0);
        write_reg(bkhs_pkg::CFG_WEIGHTED, 32'd0);
        random_phase(120, 0);
        write_reg(bkhs_pkg::CFG_KEEP, 32'd256);
        write_reg(bkhs_pkg::CFG_THRESHOLD, 32'd4);
        random_phase(250, 62);
        // Hold off until all pops have come, then carry on.
        wait_drained();
        write_reg(bkhs_pkg::CFG_WEIGHTED, 32'd1);
        write_reg(bkhs_pkg::CFG_THRESHOLD, 32'd0);
        write_reg(bkhs_pkg::CFG_KEEP, 32'd9);
        random_phase(250, 0);
        write_reg(bkhs_pkg::CFG_KEEP, 32'h1FF);
        random_phase(200, 6);
        write_reg(bkhs_pkg::CFG_KEEP, 32'd1);
        write_reg(bkhs_pkg::CFG_WEIGHTED, 32'd0);
        random_phase(150, 62);
        write_reg(bkhs_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
        random_phase(40, 0);
        write_reg(bkhs_pkg::CFG_THRESHOLD, 32'hFFFF_FFFE);
        write_reg(bkhs_pkg::CFG_KEEP, 32'd33);
        random_phase(250, 0);

        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
